/* hw/rtl/lslf_pkg.sv */
package lslf_pkg;

	localparam int MAX_POINTS = 65536;
	localparam int X_BITS = 12;
	localparam int Y_BITS = 12;
	localparam int FRAC_BITS = 16;

	localparam int CNT_W = 17;
	localparam int SX_W = 28;
	localparam int SXX_W = 40;
	localparam int SXY_W = 41;
	localparam int SY_W = 29;
	localparam int OUT_W = 48;
	localparam int NUM_W = 60;
	localparam int PRD_W = 76;
	localparam int DIV_W = 80;
	localparam int DVS_W = 40;
	localparam int DCNT_W = 7;
	localparam int HALF_W = OUT_W / 2;

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [SX_W-1:0] sx;
		logic [SXX_W-1:0] sxx;
		logic signed [SXY_W-1:0] sxy;
		logic signed [SY_W-1:0] sy;
	} job_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MXX,
		B_DXX,
		B_MXY,
		B_DXY,
		B_DSL,
		B_MLO,
		B_MHI,
		B_DIC,
		B_OUT
	} back_state_t;

	function automatic logic [OUT_W-1:0] sat_out(input logic [DIV_W-1:0] q, input logic neg);
		logic [DIV_W-1:0] lim;
		logic [OUT_W-1:0] r;
		lim = DIV_W'(1) << (OUT_W - 1);
		if (neg) begin
			if (q >= lim) r = {1'b1, {(OUT_W-1){1'b0}}};
			else r = OUT_W'(~q[OUT_W-1:0] + OUT_W'(1));
		end else begin
			if (q >= lim) r = {1'b0, {(OUT_W-1){1'b1}}};
			else r = q[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/lslf_front.sv */
module lslf_front (
	input  logic clk,
	input  logic arst_n,
	input  logic acc,
	input  logic [lslf_pkg::X_BITS-1:0] x_value,
	input  logic signed [lslf_pkg::Y_BITS-1:0] y_value,
	input  logic last_point,
	output logic job_push,
	output lslf_pkg::job_t job
);

	logic [lslf_pkg::CNT_W-1:0] cnt_q;
	logic [lslf_pkg::SX_W-1:0] sx_q;
	logic [lslf_pkg::SXX_W-1:0] sxx_q;
	logic signed [lslf_pkg::SXY_W-1:0] sxy_q;
	logic signed [lslf_pkg::SY_W-1:0] sy_q;
	logic add;
	logic [2*lslf_pkg::X_BITS-1:0] xx;
	logic signed [lslf_pkg::X_BITS+lslf_pkg::Y_BITS:0] xy;

	assign add = cnt_q < lslf_pkg::CNT_W'(lslf_pkg::MAX_POINTS);
	assign xx = x_value * x_value;
	assign xy = $signed({1'b0, x_value}) * y_value;

	always_comb begin
		job.n = cnt_q;
		job.sx = sx_q;
		job.sxx = sxx_q;
		job.sxy = sxy_q;
		job.sy = sy_q;
		if (add) begin
			job.n = cnt_q + lslf_pkg::CNT_W'(1);
			job.sx = sx_q + lslf_pkg::SX_W'(x_value);
			job.sxx = sxx_q + lslf_pkg::SXX_W'(xx);
			job.sxy = sxy_q + lslf_pkg::SXY_W'(xy);
			job.sy = sy_q + lslf_pkg::SY_W'(y_value);
		end
	end

	assign job_push = acc && last_point;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
			sy_q <= '0;
		end else if (acc) begin
			if (last_point) begin
				cnt_q <= '0;
				sx_q <= '0;
				sxx_q <= '0;
				sxy_q <= '0;
				sy_q <= '0;
			end else begin
				cnt_q <= job.n;
				sx_q <= job.sx;
				sxx_q <= job.sxx;
				sxy_q <= job.sxy;
				sy_q <= job.sy;
			end
		end
	end

endmodule

/* hw/rtl/lslf_jobq.sv */
module lslf_jobq (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  lslf_pkg::job_t wr_job,
	input  logic pop,
	output lslf_pkg::job_t rd_job,
	output logic full,
	output logic avail
);

	lslf_pkg::job_t slot_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign avail = cnt_q != 2'd0;
	assign rd_job = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* hw/rtl/lslf_div.sv */
module lslf_div (
	input  logic clk,
	input  logic arst_n,
	input  lslf_pkg::div_req_t req,
	output lslf_pkg::div_rsp_t rsp
);

	logic [lslf_pkg::DIV_W-1:0] dd_q;
	logic [lslf_pkg::DIV_W-1:0] q_q;
	logic [lslf_pkg::DVS_W-1:0] dvs_q;
	logic [lslf_pkg::DVS_W-1:0] rem_q;
	logic [lslf_pkg::DCNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [lslf_pkg::DVS_W:0] trial;
	logic [lslf_pkg::DVS_W:0] diff;
	logic ge;

	assign trial = {rem_q, dd_q[lslf_pkg::DIV_W-1]};
	assign ge = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = q_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			dd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			dd_q <= dd_q << 1;
			rem_q <= ge ? diff[lslf_pkg::DVS_W-1:0] : trial[lslf_pkg::DVS_W-1:0];
			q_q <= {q_q[lslf_pkg::DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + lslf_pkg::DCNT_W'(1);
				if (cnt_q == lslf_pkg::DCNT_W'(lslf_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* hw/rtl/lslf_back.sv */
module lslf_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_avail,
	input  lslf_pkg::job_t job,
	output logic job_pop,
	input  logic pop,
	output logic empty,
	output logic signed [lslf_pkg::OUT_W-1:0] slope,
	output logic signed [lslf_pkg::OUT_W-1:0] intercept,
	output logic degenerate
);

	lslf_pkg::back_state_t state_q;
	lslf_pkg::back_state_t state_d;
	lslf_pkg::job_t job_q;
	lslf_pkg::div_req_t dreq;
	lslf_pkg::div_rsp_t drsp;

	logic [lslf_pkg::PRD_W-1:0] prod_q;
	logic [lslf_pkg::DVS_W-1:0] den_q;
	logic signed [lslf_pkg::NUM_W-1:0] num_q;
	logic [lslf_pkg::OUT_W-1:0] slope_q;
	logic [lslf_pkg::OUT_W-1:0] icpt_q;
	logic degen_q;
	logic ovalid_q;
	logic [lslf_pkg::OUT_W-1:0] oslope_q;
	logic [lslf_pkg::OUT_W-1:0] oicpt_q;
	logic odegen_q;
	logic out_wr;

	logic sy_neg;
	logic [lslf_pkg::SY_W-1:0] sy_mag;
	logic [lslf_pkg::DVS_W-1:0] den_d;
	logic den_zero;
	logic signed [lslf_pkg::NUM_W-1:0] t1;
	logic signed [lslf_pkg::NUM_W-1:0] num_d;
	logic [lslf_pkg::NUM_W-1:0] num_mag;
	logic [lslf_pkg::OUT_W-1:0] sl_mag;
	logic signed [lslf_pkg::DIV_W-1:0] prod_s;
	logic signed [lslf_pkg::DIV_W-1:0] wn;
	logic [lslf_pkg::DIV_W-1:0] wn_mag;

	lslf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	assign sy_neg = job_q.sy[lslf_pkg::SY_W-1];
	assign sy_mag = sy_neg ? lslf_pkg::SY_W'(-job_q.sy) : lslf_pkg::SY_W'(job_q.sy);
	assign den_zero = drsp.quotient >= lslf_pkg::DIV_W'(job_q.sxx);
	assign den_d = job_q.sxx - drsp.quotient[lslf_pkg::DVS_W-1:0];
	assign t1 = sy_neg ? -$signed(drsp.quotient[lslf_pkg::NUM_W-1:0])
		: $signed(drsp.quotient[lslf_pkg::NUM_W-1:0]);
	assign num_d = lslf_pkg::NUM_W'(job_q.sxy) - t1;
	assign num_mag = num_q[lslf_pkg::NUM_W-1] ? lslf_pkg::NUM_W'(-num_q)
		: lslf_pkg::NUM_W'(num_q);
	assign sl_mag = slope_q[lslf_pkg::OUT_W-1] ? ~slope_q + lslf_pkg::OUT_W'(1) : slope_q;
	assign prod_s = slope_q[lslf_pkg::OUT_W-1] ? -$signed({4'b0, prod_q})
		: $signed({4'b0, prod_q});
	assign wn = (lslf_pkg::DIV_W'(job_q.sy) <<< lslf_pkg::FRAC_BITS) - prod_s;
	assign wn_mag = wn[lslf_pkg::DIV_W-1] ? lslf_pkg::DIV_W'(-wn) : lslf_pkg::DIV_W'(wn);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lslf_pkg::B_IDLE: if (job_avail) state_d = lslf_pkg::B_MXX;
			lslf_pkg::B_MXX: state_d = lslf_pkg::B_DXX;
			lslf_pkg::B_DXX: if (drsp.done) state_d = lslf_pkg::B_MXY;
			lslf_pkg::B_MXY: state_d = den_zero ? lslf_pkg::B_OUT : lslf_pkg::B_DXY;
			lslf_pkg::B_DXY: if (drsp.done) state_d = lslf_pkg::B_DSL;
			lslf_pkg::B_DSL: if (drsp.done) state_d = lslf_pkg::B_MLO;
			lslf_pkg::B_MLO: state_d = lslf_pkg::B_MHI;
			lslf_pkg::B_MHI: state_d = lslf_pkg::B_DIC;
			lslf_pkg::B_DIC: if (drsp.done) state_d = lslf_pkg::B_OUT;
			lslf_pkg::B_OUT: if (!ovalid_q || pop) state_d = lslf_pkg::B_IDLE;
			default: state_d = lslf_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		job_pop = 1'b0;
		out_wr = 1'b0;
		dreq.start = 1'b0;
		dreq.dividend = {lslf_pkg::DIV_W'(0) | lslf_pkg::DIV_W'(prod_q)};
		dreq.divisor = lslf_pkg::DVS_W'(job_q.n);
		unique case (state_q)
			lslf_pkg::B_IDLE: job_pop = job_avail;
			lslf_pkg::B_DXX, lslf_pkg::B_DXY: dreq.start = !drsp.busy && !drsp.done;
			lslf_pkg::B_DSL: begin
				dreq.start = !drsp.busy && !drsp.done;
				dreq.dividend = lslf_pkg::DIV_W'(num_mag) << lslf_pkg::FRAC_BITS;
				dreq.divisor = den_q;
			end
			lslf_pkg::B_DIC: begin
				dreq.start = !drsp.busy && !drsp.done;
				dreq.dividend = wn_mag;
			end
			lslf_pkg::B_OUT: out_wr = !ovalid_q || pop;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lslf_pkg::B_IDLE: job_q <= job;
			lslf_pkg::B_MXX: prod_q <= lslf_pkg::PRD_W'(job_q.sx * job_q.sx);
			lslf_pkg::B_MXY: begin
				prod_q <= lslf_pkg::PRD_W'(job_q.sx * sy_mag);
				den_q <= den_d;
				degen_q <= den_zero;
				slope_q <= '0;
				icpt_q <= '0;
			end
			lslf_pkg::B_DXY: if (drsp.done) num_q <= num_d;
			lslf_pkg::B_DSL: if (drsp.done) slope_q <= lslf_pkg::sat_out(drsp.quotient,
				num_q[lslf_pkg::NUM_W-1]);
			lslf_pkg::B_MLO: prod_q <= lslf_pkg::PRD_W'(sl_mag[lslf_pkg::HALF_W-1:0] * job_q.sx);
			lslf_pkg::B_MHI: prod_q <= prod_q + (lslf_pkg::PRD_W'(
				sl_mag[lslf_pkg::OUT_W-1:lslf_pkg::HALF_W] * job_q.sx) << lslf_pkg::HALF_W);
			lslf_pkg::B_DIC: if (drsp.done) icpt_q <= lslf_pkg::sat_out(drsp.quotient,
				wn[lslf_pkg::DIV_W-1]);
			default: ;
		endcase
		if (out_wr) begin
			oslope_q <= slope_q;
			oicpt_q <= icpt_q;
			odegen_q <= degen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lslf_pkg::B_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_wr) ovalid_q <= 1'b1;
			else if (pop) ovalid_q <= 1'b0;
		end
	end

	assign empty = !ovalid_q;
	assign slope = oslope_q;
	assign intercept = oicpt_q;
	assign degenerate = odegen_q;

endmodule

/* hw/rtl/least_squares_line_fit_unit.sv */
// Straight-line least-squares fit over a stream of points.
// Points are written through a queue-style port: an item is taken at a
// rising edge where push is high and full is low. Each point is added to
// the running sums in the cycle it is taken, so points stream at one per
// cycle while full is low. The point marked last closes the series and
// hands its sums to a two-entry job queue; full rises only while that
// queue holds two series. The fit runs from the job queue through one
// shared radix-2 divider. Each division runs 80 steps between its start
// and its finish, and a series uses it four times; a degenerate series
// needs one division.
// Results are read through a queue-style port: while empty is low the
// oldest result stands on slope, intercept and degenerate, and pop takes it.
// A result that is not popped holds; the fit of the next series completes
// into its own register stage and then waits, and points keep streaming
// until the job queue fills.
// Reset clears the sums, the job queue and the result valid flag, so the
// block comes up with full and empty deasserted and asserted respectively.
module least_squares_line_fit_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [lslf_pkg::X_BITS-1:0] x_value,
	input  logic signed [lslf_pkg::Y_BITS-1:0] y_value,
	input  logic last_point,
	input  logic pop,
	output logic empty,
	output logic signed [lslf_pkg::OUT_W-1:0] slope,
	output logic signed [lslf_pkg::OUT_W-1:0] intercept,
	output logic degenerate
);

	logic acc;
	logic job_push;
	logic job_pop;
	logic job_avail;
	lslf_pkg::job_t wr_job;
	lslf_pkg::job_t rd_job;

	assign acc = push && !full;

	lslf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.x_value(x_value),
		.y_value(y_value),
		.last_point(last_point),
		.job_push(job_push),
		.job(wr_job)
	);

	lslf_jobq u_jobq (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.wr_job(wr_job),
		.pop(job_pop),
		.rd_job(rd_job),
		.full(full),
		.avail(job_avail)
	);

	lslf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_avail(job_avail),
		.job(rd_job),
		.job_pop(job_pop),
		.pop(pop),
		.empty(empty),
		.slope(slope),
		.intercept(intercept),
		.degenerate(degenerate)
	);

endmodule

/* hw/rtl/lslf_checker.sv */
module lslf_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  logic last_point,
	input  logic pop,
	input  logic empty,
	input  logic signed [lslf_pkg::OUT_W-1:0] slope,
	input  logic signed [lslf_pkg::OUT_W-1:0] intercept,
	input  logic degenerate
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("Result queue or input full during reset.");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && degenerate |-> slope == '0 && intercept == '0)
		else $error("Degenerate result with nonzero fields.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(slope) && $stable(intercept)
			&& $stable(degenerate))
		else $error("Waiting result changed before it was taken.");

	a_full_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && last_point))
		else $error("Input became full without a closing request.");

endmodule

bind least_squares_line_fit_unit lslf_checker u_lslf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.push(push),
	.full(full),
	.last_point(last_point),
	.pop(pop),
	.empty(empty),
	.slope(slope),
	.intercept(intercept),
	.degenerate(degenerate)
);
